// ===== hdl/wsa_pkg.sv =====
// Shared types, codes and saturation helpers for the weighted scatter accumulator.
// No dependencies; imported by the controller, datapath and top level.
package wsa_pkg;

  // request modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_OBS    = 2'd1;
  localparam logic [1:0] MODE_RD_ST  = 2'd2;
  localparam logic [1:0] MODE_RD_MO  = 2'd3;

  // register index of first_pass (paddr[2])
  localparam logic REG_FIRST_PASS = 1'b0;

  // index compare width, holds the largest station / month count (4096)
  localparam int IDX_W  = 13;
  // weight table address arithmetic width
  localparam int WADR_W = 24;

  typedef struct packed {
    logic capture;   // register the request fields
    logic load;      // write the weight table
    logic mul;       // register |w| and w * temperature
    logic wb;        // write back both accumulator rows
    logic out_load;  // load the result register
    logic clr;       // clearing pass, one row per cycle
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       skip;      // observation that does nothing
    logic       addr_ok;   // load indices in range
    logic       clr_last;
  } dp_sts_t;

  typedef struct packed {
    logic [39:0] wsum;
    logic [15:0] cnt;
    logic [31:0] tsum;
  } st_acc_t;

  typedef struct packed {
    logic [31:0] wsum;
    logic [47:0] wtemp;
  } mo_acc_t;

  function automatic logic [31:0] sat_s32(input logic signed [32:0] x);
    logic [31:0] r;
    if (x[32] != x[31]) r = x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic [47:0] sat_s48(input logic signed [48:0] x);
    logic [47:0] r;
    if (x[48] != x[47]) r = x[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    else r = x[47:0];
    return r;
  endfunction

endpackage

// ===== hdl/weighted_scatter_accumulate.sv =====
// Weighted scatter accumulator top level: config register, controller and datapath.
// Depends on wsa_pkg, wsa_ctrl and wsa_dp.
// One request at a time. A load or skipped observation ends after the read step; a
// station/month read adds an output step that waits for a free result register and
// loads it; an observation adds the multiply and write-back steps on the accumulator
// memories. Reset (rst_n low, synchronous) starts a clearing pass of max(STATIONS,
// MONTHS) rows with in_ready low; first_pass resets to 1, config writes taken throughout.
module weighted_scatter_accumulate import wsa_pkg::*; #(
  parameter int STATIONS = 256,
  parameter int MONTHS   = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_station,
  input  logic [9:0]         in_month,
  input  logic signed [15:0] in_weight,
  input  logic signed [15:0] in_temperature,
  input  logic               in_station_excluded,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [39:0]        out_station_weight_sum,
  output logic [15:0]        out_station_count,
  output logic signed [31:0] out_station_temp_sum,
  output logic signed [31:0] out_month_weight_sum,
  output logic signed [47:0] out_month_weighted_temp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    first_pass_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FIRST_PASS) ? {31'd0, first_pass_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_pass_r <= 1'b1;
    end else if (psel && penable && pwrite && paddr[2] == REG_FIRST_PASS) begin
      first_pass_r <= pwdata[0];
    end
  end

  wsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wsa_dp #(
    .STATIONS (STATIONS),
    .MONTHS   (MONTHS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .first_pass              (first_pass_r),
    .in_mode                 (in_mode),
    .in_station              (in_station),
    .in_month                (in_month),
    .in_weight               (in_weight),
    .in_temperature          (in_temperature),
    .in_station_excluded     (in_station_excluded),
    .out_station_weight_sum  (out_station_weight_sum),
    .out_station_count       (out_station_count),
    .out_station_temp_sum    (out_station_temp_sum),
    .out_month_weight_sum    (out_month_weight_sum),
    .out_month_weighted_temp (out_month_weighted_temp)
  );

endmodule

// ===== hdl/wsa_ctrl.sv =====
// Sequencer for the weighted scatter accumulator: clearing pass, per-request steps.
// Depends on wsa_pkg; drives wsa_dp through dp_cmd_t and reads dp_sts_t.
module wsa_ctrl import wsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CALC,
    S_WRITE,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        unique case (sts.mode)
          MODE_LOAD: begin
            cmd.load  = sts.addr_ok;
            state_nxt = S_IDLE;
          end
          MODE_OBS:  state_nxt = sts.skip ? S_IDLE : S_CALC;
          default:   state_nxt = S_OUT;
        endcase
      end
      S_CALC: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        cmd.wb    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/wsa_dp.sv =====
// Datapath: weight table, station and month accumulator memories, saturating update.
// Depends on wsa_pkg; sequenced by wsa_ctrl.
module wsa_dp import wsa_pkg::*; #(
  parameter int STATIONS = 256,
  parameter int MONTHS   = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               first_pass,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_station,
  input  logic [9:0]         in_month,
  input  logic signed [15:0] in_weight,
  input  logic signed [15:0] in_temperature,
  input  logic               in_station_excluded,
  output logic [39:0]        out_station_weight_sum,
  output logic [15:0]        out_station_count,
  output logic signed [31:0] out_station_temp_sum,
  output logic signed [31:0] out_month_weight_sum,
  output logic signed [47:0] out_month_weighted_temp
);

  localparam int WDEPTH = STATIONS * MONTHS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SAW    = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int MAW    = (MONTHS > 1) ? $clog2(MONTHS) : 1;
  localparam int CLR_N  = (STATIONS > MONTHS) ? STATIONS : MONTHS;
  localparam int CLR_W  = (CLR_N > 1) ? $clog2(CLR_N) : 1;

  // captured request
  logic [1:0]  mode_r;
  logic [7:0]  st_r;
  logic [9:0]  mo_r;
  logic [15:0] w_in_r;
  logic [15:0] temp_r;
  logic        excl_r;

  logic [15:0] wmem [WDEPTH];
  st_acc_t     st_mem [STATIONS];
  mo_acc_t     mo_mem [MONTHS];

  logic [15:0] w_rd_r;
  st_acc_t     st_rd_r;
  mo_acc_t     mo_rd_r;

  logic [15:0]        aw_r;
  logic signed [31:0] p_r;

  logic [CLR_W-1:0] clr_r;

  logic             st_ok, mo_ok;
  logic [WADR_W-1:0] wa_full;
  logic [WAW-1:0]   w_addr;
  logic [SAW-1:0]   st_idx;
  logic [MAW-1:0]   mo_idx;
  logic             clr_st, clr_mo;

  st_acc_t            st_new;
  mo_acc_t            mo_new;
  logic [40:0]        wsum41;
  logic signed [32:0] ts33, dw33;
  logic signed [48:0] wt49;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      st_r   <= in_station;
      mo_r   <= in_month;
      w_in_r <= in_weight;
      temp_r <= in_temperature;
      excl_r <= in_station_excluded;
    end
  end

  assign st_ok   = IDX_W'(st_r) < IDX_W'(STATIONS);
  assign mo_ok   = IDX_W'(mo_r) < IDX_W'(MONTHS);
  assign wa_full = WADR_W'(st_r) * WADR_W'(MONTHS) + WADR_W'(mo_r);
  assign w_addr  = wa_full[WAW-1:0];
  assign st_idx  = SAW'(st_r);
  assign mo_idx  = MAW'(mo_r);

  assign sts.mode     = mode_r;
  assign sts.addr_ok  = st_ok && mo_ok;
  assign sts.skip     = !(st_ok && mo_ok) || (!first_pass && excl_r);
  assign sts.clr_last = (clr_r == CLR_W'(CLR_N - 1));

  // clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr && !sts.clr_last) begin
      clr_r <= clr_r + CLR_W'(1);
    end
  end

  assign clr_st = cmd.clr && (IDX_W'(clr_r) < IDX_W'(STATIONS));
  assign clr_mo = cmd.clr && (IDX_W'(clr_r) < IDX_W'(MONTHS));

  // weight table
  always_ff @(posedge clk) begin
    if (cmd.load) wmem[w_addr] <= w_in_r;
    w_rd_r <= wmem[w_addr];
  end

  // product and magnitude, registered in the step after the reads
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_r  <= 32'($signed(w_rd_r)) * 32'($signed(temp_r));
      aw_r <= w_rd_r[15] ? 16'(-w_rd_r) : w_rd_r;
    end
  end

  // saturating updates
  always_comb begin
    wsum41       = {1'b0, st_rd_r.wsum} + 41'(aw_r);
    st_new.wsum  = wsum41[40] ? '1 : wsum41[39:0];
    st_new.cnt   = (&st_rd_r.cnt) ? st_rd_r.cnt : st_rd_r.cnt + 16'd1;
    ts33         = $signed({st_rd_r.tsum[31], st_rd_r.tsum}) + 33'($signed(temp_r));
    st_new.tsum  = sat_s32(ts33);
    dw33         = $signed({mo_rd_r.wsum[31], mo_rd_r.wsum}) + 33'($signed(w_rd_r));
    mo_new.wsum  = sat_s32(dw33);
    wt49         = $signed({mo_rd_r.wtemp[47], mo_rd_r.wtemp}) + 49'(p_r);
    mo_new.wtemp = sat_s48(wt49);
  end

  always_ff @(posedge clk) begin
    if (clr_st) st_mem[clr_r[SAW-1:0]] <= '0;
    else if (cmd.wb) st_mem[st_idx] <= st_new;
    st_rd_r <= st_mem[st_idx];
  end

  always_ff @(posedge clk) begin
    if (clr_mo) mo_mem[clr_r[MAW-1:0]] <= '0;
    else if (cmd.wb) mo_mem[mo_idx] <= mo_new;
    mo_rd_r <= mo_mem[mo_idx];
  end

  // result register; fields of the other group read as zero
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_station_weight_sum  <= '0;
      out_station_count       <= '0;
      out_station_temp_sum    <= '0;
      out_month_weight_sum    <= '0;
      out_month_weighted_temp <= '0;
      if (mode_r == MODE_RD_ST && st_ok) begin
        out_station_weight_sum <= st_rd_r.wsum;
        out_station_count      <= st_rd_r.cnt;
        out_station_temp_sum   <= $signed(st_rd_r.tsum);
      end
      if (mode_r == MODE_RD_MO && mo_ok) begin
        out_month_weight_sum    <= $signed(mo_rd_r.wsum);
        out_month_weighted_temp <= $signed(mo_rd_r.wtemp);
      end
    end
  end

endmodule

// ===== hdl/wsa_checker.sv =====
// Port-level checks for weighted_scatter_accumulate, attached by bind.
// Depends on wsa_pkg for the request mode codes.
module wsa_checker import wsa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_station_weight_sum,
  input logic [47:0] out_month_weighted_temp,
  input logic        pready
);

  // clearing pass blocks requests right after reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("in_ready high right after reset");

  // one request in flight at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  // loads and observations never produce a result
  a_no_result_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == MODE_LOAD || in_mode == MODE_OBS))
    |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result produced by a load or observation");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_station_weight_sum)
    && $stable(out_month_weighted_temp))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind weighted_scatter_accumulate wsa_checker u_wsa_checker (.*);

// ===== dv/wsa_sum_checker.sv =====
// Result checker for weighted_scatter_accumulate: watches the request, result and
// register ports, mirrors the weight table and the sums, and counts mismatches.
// Depends on wsa_pkg.
module wsa_sum_checker import wsa_pkg::*; #(
  parameter int STATIONS = 256,
  parameter int MONTHS   = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_station,
  input  logic [9:0]         in_month,
  input  logic signed [15:0] in_weight,
  input  logic signed [15:0] in_temperature,
  input  logic               in_station_excluded,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [39:0]        out_station_weight_sum,
  input  logic [15:0]        out_station_count,
  input  logic signed [31:0] out_station_temp_sum,
  input  logic signed [31:0] out_month_weight_sum,
  input  logic signed [47:0] out_month_weighted_temp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int unsigned        mismatches,
  output int unsigned        sums_pending
);

  localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN = -S32_MAX - 1;
  localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -S48_MAX - 1;

  typedef struct packed {
    logic [39:0] st_wsum;
    logic [15:0] st_cnt;
    logic [31:0] st_tsum;
    logic [31:0] mo_wsum;
    logic [47:0] mo_wtemp;
  } sums_t;

  logic signed [15:0] weights [logic [17:0]];
  st_acc_t            station_sums [STATIONS];
  mo_acc_t            month_sums [MONTHS];
  logic               first_pass;
  sums_t              sums_due [$];

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void accumulate_request(logic [1:0] mode, logic [7:0] st,
      logic [9:0] mo, logic signed [15:0] w_in, logic signed [15:0] temp, logic excl);
    logic [17:0] key;
    longint      w;
    longint      acc;
    sums_t       r;
    key = {st, mo};
    r = '0;
    case (mode)
      MODE_LOAD: begin
        if (st < STATIONS && mo < MONTHS) weights[key] = w_in;
      end
      MODE_OBS: begin
        if (st < STATIONS && mo < MONTHS && !(!first_pass && excl)) begin
          w = weights.exists(key) ? longint'(weights[key]) : 64'sd0;
          acc = station_sums[st].wsum;
          acc += (w < 0) ? -w : w;
          station_sums[st].wsum = (acc > 64'sh00FF_FFFF_FFFF) ? '1 : acc[39:0];
          if (station_sums[st].cnt != 16'hFFFF) station_sums[st].cnt++;
          acc = $signed(station_sums[st].tsum);
          acc = clamp(acc + temp, S32_MIN, S32_MAX);
          station_sums[st].tsum = acc[31:0];
          acc = $signed(month_sums[mo].wsum);
          acc = clamp(acc + w, S32_MIN, S32_MAX);
          month_sums[mo].wsum = acc[31:0];
          acc = $signed(month_sums[mo].wtemp);
          acc = clamp(acc + w * temp, S48_MIN, S48_MAX);
          month_sums[mo].wtemp = acc[47:0];
        end
      end
      MODE_RD_ST: begin
        if (st < STATIONS) begin
          r.st_wsum = station_sums[st].wsum;
          r.st_cnt  = station_sums[st].cnt;
          r.st_tsum = station_sums[st].tsum;
        end
        sums_due.push_back(r);
      end
      MODE_RD_MO: begin
        if (mo < MONTHS) begin
          r.mo_wsum  = month_sums[mo].wsum;
          r.mo_wtemp = month_sums[mo].wtemp;
        end
        sums_due.push_back(r);
      end
    endcase
  endfunction

  function automatic void check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, expv, actv);
    end
  endfunction

  always @(posedge clk) begin : watch
    sums_t exp_sums;
    if (!rst_n) begin
      weights.delete();
      foreach (station_sums[i]) station_sums[i] = '0;
      foreach (month_sums[i]) month_sums[i] = '0;
      first_pass = 1'b1;
      sums_due.delete();
      mismatches = 0;
    end else begin
      // retire results before taking the request of the same edge
      if (out_valid && out_ready) begin
        if (sums_due.size() == 0) begin
          mismatches++;
          $error("result with no read request waiting");
        end else begin
          exp_sums = sums_due.pop_front();
          check_field("station_weight_sum", exp_sums.st_wsum, out_station_weight_sum);
          check_field("station_count", exp_sums.st_cnt, out_station_count);
          check_field("station_temp_sum", $signed(exp_sums.st_tsum), out_station_temp_sum);
          check_field("month_weight_sum", $signed(exp_sums.mo_wsum), out_month_weight_sum);
          check_field("month_weighted_temp", $signed(exp_sums.mo_wtemp),
                      out_month_weighted_temp);
        end
      end
      if (in_valid && in_ready)
        accumulate_request(in_mode, in_station, in_month, in_weight, in_temperature,
                           in_station_excluded);
      if (psel && penable && pwrite && pready && paddr[2] == REG_FIRST_PASS)
        first_pass = pwdata[0];
    end
    sums_pending = sums_due.size();
  end

endmodule

// ===== dv/weighted_scatter_accumulate_test.sv =====
// Testbench top for weighted_scatter_accumulate: reset, register writes, directed and
// random requests with random idling, a same-entry run, and the verdict.
// Depends on wsa_pkg, weighted_scatter_accumulate and wsa_sum_checker.
module weighted_scatter_accumulate_test;
  import wsa_pkg::*;

  localparam logic [2:0] FIRST_PASS_ADDR = {REG_FIRST_PASS, 2'b00};
  // back-to-back observations of one entry
  localparam int HOT_OBSERVATIONS = 24;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = MODE_LOAD;
  logic [7:0]         in_station = '0;
  logic [9:0]         in_month = '0;
  logic signed [15:0] in_weight = '0;
  logic signed [15:0] in_temperature = '0;
  logic               in_station_excluded = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [39:0]        out_station_weight_sum;
  logic [15:0]        out_station_count;
  logic signed [31:0] out_station_temp_sum;
  logic signed [31:0] out_month_weight_sum;
  logic signed [47:0] out_month_weighted_temp;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned mismatches;
  int unsigned sums_pending;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned tx_quiet = 0;
  int unsigned rx_quiet = 0;
  logic [17:0] loaded_keys [$];
  bit          key_loaded [logic [17:0]];
  logic [17:0] last_key = '0;

  weighted_scatter_accumulate uut (.*);
  wsa_sum_checker sum_check (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side stalls, with occasional stretches of steady ready
  always @(posedge clk) begin
    if (rx_quiet != 0) begin
      rx_quiet <= rx_quiet - 1;
      out_ready <= 1'b1;
    end else if ($urandom_range(199) == 0) begin
      rx_quiet <= $urandom_range(50, 20);
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // small index pools make back-to-back hits on one row common
  function automatic logic [7:0] pick_station();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return 8'($urandom_range(3));
    if (r == 6) return 8'd255;
    return 8'($urandom);
  endfunction

  function automatic logic [9:0] pick_month();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6) return 10'($urandom_range(3));
    if (r == 6) return 10'd1023;
    return 10'($urandom);
  endfunction

  task automatic send(logic [1:0] mode, logic [7:0] st, logic [9:0] mo, logic [15:0] w,
                      logic [15:0] t, logic excl);
    if (tx_quiet != 0) tx_quiet--;
    else begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_station <= st;
    in_month <= mo;
    in_weight <= w;
    in_temperature <= t;
    in_station_excluded <= excl;
    if (mode == MODE_LOAD && !key_loaded.exists({st, mo})) begin
      key_loaded[{st, mo}] = 1'b1;
      loaded_keys.push_back({st, mo});
    end
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_first_pass(logic value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FIRST_PASS_ADDR;
    pwdata <= {31'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait for all reads to return plus the observation write-back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_requests(int unsigned count);
    logic [17:0] key;
    int unsigned pick;
    repeat (count) begin
      if (tx_quiet == 0 && $urandom_range(24) == 0) tx_quiet = $urandom_range(40, 15);
      key = {pick_station(), pick_month()};
      pick = $urandom_range(99);
      if (pick < 20 || loaded_keys.size() == 0) begin
        send(MODE_LOAD, key[17:10], key[9:0], pick_value(), 16'($urandom), 1'($urandom));
      end else if (pick < 70) begin
        // only loaded entries are observed; a third repeat the previous entry
        if ($urandom_range(2) != 0) last_key = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
        send(MODE_OBS, last_key[17:10], last_key[9:0], 16'($urandom), pick_value(),
             1'($urandom));
      end else if (pick < 85) begin
        send(MODE_RD_ST, key[17:10], key[9:0], 16'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        send(MODE_RD_MO, key[17:10], key[9:0], 16'($urandom), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // second pass: excluded stations are dropped
    write_first_pass(1'b0);
    send(MODE_LOAD, 8'd0, 10'd0, 16'h8000, 16'h0000, 1'b0);
    send(MODE_LOAD, 8'd255, 10'd1023, 16'h7FFF, 16'hFFFF, 1'b1);
    send(MODE_LOAD, 8'd0, 10'd1023, 16'h0001, 16'h0000, 1'b0);
    send(MODE_OBS, 8'd0, 10'd0, 16'h0000, 16'h7FFF, 1'b0);
    send(MODE_OBS, 8'd0, 10'd0, 16'h0000, 16'h8000, 1'b1);
    send(MODE_OBS, 8'd255, 10'd1023, 16'hFFFF, 16'h8000, 1'b0);
    send(MODE_OBS, 8'd0, 10'd1023, 16'h0000, 16'hFFFF, 1'b0);
    send(MODE_RD_ST, 8'd0, 10'd1023, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_ST, 8'd255, 10'd0, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_ST, 8'd17, 10'd0, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_MO, 8'd255, 10'd0, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_MO, 8'd0, 10'd1023, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_MO, 8'd0, 10'd500, 16'h0000, 16'h0000, 1'b0);
    settle();

    // first pass: excluded stations still count
    write_first_pass(1'b1);
    send(MODE_OBS, 8'd0, 10'd0, 16'h0000, 16'h8000, 1'b1);
    send(MODE_OBS, 8'd255, 10'd1023, 16'h0000, 16'h7FFF, 1'b1);
    send(MODE_RD_ST, 8'd0, 10'd0, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_MO, 8'd0, 10'd0, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_ST, 8'd255, 10'd1023, 16'h0000, 16'h0000, 1'b0);
    send(MODE_RD_MO, 8'd255, 10'd1023, 16'h0000, 16'h0000, 1'b0);
    settle();

    tx_idle_pct = 25;
    rx_idle_pct <= 85;
    random_requests(200);
    settle();

    write_first_pass(1'b0);
    tx_idle_pct = 85;
    rx_idle_pct <= 25;
    random_requests(200);
    settle();

    write_first_pass(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    tx_quiet = 0;
    random_requests(110);

    // hammer one station and one month with extreme values, then flip the weight sign
    send(MODE_LOAD, 8'd200, 10'd900, 16'h8000, 16'($urandom), 1'($urandom));
    repeat (HOT_OBSERVATIONS)
      send(MODE_OBS, 8'd200, 10'd900, 16'($urandom), 16'h7FFF, 1'($urandom));
    send(MODE_RD_ST, 8'd200, 10'd900, 16'($urandom), 16'($urandom), 1'($urandom));
    send(MODE_RD_MO, 8'd200, 10'd900, 16'($urandom), 16'($urandom), 1'($urandom));
    send(MODE_LOAD, 8'd200, 10'd900, 16'h7FFF, 16'($urandom), 1'($urandom));
    send(MODE_OBS, 8'd200, 10'd900, 16'($urandom), 16'h7FFF, 1'($urandom));
    send(MODE_OBS, 8'd200, 10'd900, 16'($urandom), 16'h8000, 1'($urandom));
    send(MODE_RD_ST, 8'd200, 10'd900, 16'($urandom), 16'($urandom), 1'($urandom));
    send(MODE_RD_MO, 8'd200, 10'd900, 16'($urandom), 16'($urandom), 1'($urandom));
    settle();

    if (mismatches == 0 && sums_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
